[rtl/core/ticds_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ticds_pkg: shared types and constants
// Command codes, register indexes and datapath widths for the theta sampler.
// ----------------------------------------------------------------------------
package ticds_pkg;

  typedef enum logic [1:0] {
    CMD_CDF    = 2'd0,
    CMD_SUM    = 2'd1,
    CMD_SAMPLE = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    REG_LOW_ROWS  = 2'd0,
    REG_HIGH_ROWS = 2'd1,
    REG_LIMIT     = 2'd2,
    REG_TOTAL     = 2'd3
  } reg_idx_t;

  localparam int MUL_A_W = 96;
  localparam int MUL_B_W = 48;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  localparam int DIV_N_W = 128;
  localparam int DIV_D_W = 65;
  localparam int DIV_Q_W = 32;

  localparam int SQRT_N_W = 128;
  localparam int SQRT_R_W = SQRT_N_W / 2;

  localparam logic [31:0] ONE_Q31     = 32'h8000_0000;
  localparam logic [31:0] HALF_Q31    = 32'h4000_0000;
  localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
  localparam logic [30:0] THETA_MAX   = 31'h7fff_ffff;
  localparam logic [32:0] ONE_Q32     = 33'h1_0000_0000;

endpackage
`default_nettype wire

[rtl/core/ticds_mul.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ticds_mul: bit-serial multiplier
// Shift-add multiply, one bit of b per cycle; done pulses with p valid.
// ----------------------------------------------------------------------------
module ticds_mul (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic [ticds_pkg::MUL_A_W-1:0] a,
  input  wire logic [ticds_pkg::MUL_B_W-1:0] b,
  output logic                               done,
  output logic [ticds_pkg::MUL_P_W-1:0]      p
);

  localparam int CNT_W = $clog2(ticds_pkg::MUL_B_W);

  logic [ticds_pkg::MUL_A_W-1:0] areg;
  logic [CNT_W-1:0]              cnt;
  logic                          run;
  logic [ticds_pkg::MUL_A_W:0]   sum;

  always_comb begin
    sum = {1'b0, p[ticds_pkg::MUL_P_W-1:ticds_pkg::MUL_B_W]}
        + (p[0] ? {1'b0, areg} : '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= CNT_W'(ticds_pkg::MUL_B_W - 1);
      end else if (run) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      areg <= a;
      p    <= {{ticds_pkg::MUL_A_W{1'b0}}, b};
    end else if (run) begin
      p <= {sum, p[ticds_pkg::MUL_B_W-1:1]};
    end
  end

endmodule
`default_nettype wire

[rtl/core/ticds_div.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ticds_div: bit-serial restoring divider
// One quotient bit per cycle, floor quotient saturated to cap; zero divisor
// gives zero.
// ----------------------------------------------------------------------------
module ticds_div (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic [ticds_pkg::DIV_N_W-1:0] num,
  input  wire logic [ticds_pkg::DIV_D_W-1:0] den,
  input  wire logic [ticds_pkg::DIV_Q_W-1:0] cap,
  output logic                               done,
  output logic [ticds_pkg::DIV_Q_W-1:0]      q
);

  localparam int CNT_W = $clog2(ticds_pkg::DIV_N_W);

  logic [ticds_pkg::DIV_N_W-1:0] nsh;
  logic [ticds_pkg::DIV_D_W-1:0] den_r;
  logic [ticds_pkg::DIV_D_W-1:0] rem;
  logic [ticds_pkg::DIV_Q_W-1:0] cap_r;
  logic [ticds_pkg::DIV_Q_W:0]   qr;
  logic                          sticky;
  logic                          dz;
  logic [CNT_W-1:0]              cnt;
  logic                          run;

  logic [ticds_pkg::DIV_D_W:0]   rem_sh;
  logic [ticds_pkg::DIV_D_W:0]   diff;
  logic                          ge;
  logic [ticds_pkg::DIV_Q_W:0]   q_nx;
  logic                          sticky_nx;
  logic [ticds_pkg::DIV_Q_W-1:0] res;

  always_comb begin
    rem_sh    = {rem, nsh[ticds_pkg::DIV_N_W-1]};
    diff      = rem_sh - {1'b0, den_r};
    ge        = rem_sh >= {1'b0, den_r};
    q_nx      = {qr[ticds_pkg::DIV_Q_W-1:0], ge};
    sticky_nx = sticky | qr[ticds_pkg::DIV_Q_W];
    if (dz) begin
      res = '0;
    end else if (sticky_nx || (q_nx > {1'b0, cap_r})) begin
      res = cap_r;
    end else begin
      res = q_nx[ticds_pkg::DIV_Q_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= CNT_W'(ticds_pkg::DIV_N_W - 1);
      end else if (run) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      nsh    <= num;
      den_r  <= den;
      cap_r  <= cap;
      dz     <= (den == '0);
      rem    <= '0;
      qr     <= '0;
      sticky <= 1'b0;
    end else if (run) begin
      nsh    <= {nsh[ticds_pkg::DIV_N_W-2:0], 1'b0};
      rem    <= ge ? diff[ticds_pkg::DIV_D_W-1:0] : rem_sh[ticds_pkg::DIV_D_W-1:0];
      qr     <= q_nx;
      sticky <= sticky_nx;
      if (cnt == '0) begin
        q <= res;
      end
    end
  end

endmodule
`default_nettype wire

[rtl/core/ticds_sqrt.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ticds_sqrt: digit-serial integer square root
// Two radicand bits per cycle, floor root; done pulses with root valid.
// ----------------------------------------------------------------------------
module ticds_sqrt (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  input  wire logic [ticds_pkg::SQRT_N_W-1:0] num,
  output logic                                done,
  output logic [ticds_pkg::SQRT_R_W-1:0]      root
);

  localparam int RW    = ticds_pkg::SQRT_R_W;
  localparam int CNT_W = $clog2(RW);

  logic [ticds_pkg::SQRT_N_W-1:0] nsh;
  logic [RW:0]                    rem;
  logic [CNT_W-1:0]               cnt;
  logic                           run;
  logic [RW+2:0]                  rem_sh;
  logic [RW+2:0]                  trial;
  logic [RW+2:0]                  diff;
  logic                           ge;

  always_comb begin
    rem_sh = {rem, nsh[ticds_pkg::SQRT_N_W-1 -: 2]};
    trial  = {1'b0, root, 2'b01};
    diff   = rem_sh - trial;
    ge     = rem_sh >= trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= CNT_W'(RW - 1);
      end else if (run) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      nsh  <= num;
      rem  <= '0;
      root <= '0;
    end else if (run) begin
      nsh  <= {nsh[ticds_pkg::SQRT_N_W-3:0], 2'b00};
      rem  <= ge ? diff[RW:0] : rem_sh[RW:0];
      root <= {root[RW-2:0], ge};
    end
  end

endmodule
`default_nettype wire

[rtl/core/theta_inverse_cdf_sampler_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// theta_inverse_cdf_sampler_core: polar angle sampler by inverse transform
// Load beats fill the CDF and row hit-sum tables; sample beats search the
// CDF, interpolate within the bin and map the position to theta.
// ----------------------------------------------------------------------------
// Input beat on s_*: tuser carries the command, tdata the table row, value
// and Q0.32 lookup. Output beat on m_*: theta Q1.30, bin index and Q1.31
// overshoot; one output beat per input beat, zeros for load and no-op commands.
// A sample takes one binary search pass and a table fetch, then serial units:
//   first/last half or linear bin: one division,
//   quadratic bin: four multiplies, a root, one division,
//   plus the theta map: one multiply and one division (skipped when the
//   high band is empty and the position falls in it).
// One item is in work at a time; s_tready is high only while idle. A finished
// result sits in the output register, so the next beat is taken while it
// waits for m_tready. Reset (rst, synchronous) restores register defaults
// and empties the output; table contents are undefined until written.
// Configuration writes (cfg_we, cfg_addr, cfg_data) are registered on the clock edge where cfg_we is high.
// ----------------------------------------------------------------------------
module theta_inverse_cdf_sampler_core #(
  parameter int ROWS       = 256,
  parameter int VALUE_BITS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [79:0] s_tdata,   // entry_index[8:0], entry_value[41:9], lookup[73:42]
  input  wire logic [1:0]  s_tuser,   // cmd[1:0]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [71:0]      m_tdata,   // theta[30:0], bin_index[39:31], overshoot[71:40]
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_addr,
  input  wire logic [47:0] cfg_data
);

  localparam int CDF_AW = $clog2(ROWS);
  localparam int SUM_AW = $clog2(ROWS + 1);
  localparam int N_W    = SUM_AW;
  localparam int CW     = (N_W > 10) ? N_W : 10;
  localparam int P_W    = N_W + 32;
  localparam int CMP_W  = (P_W > 40) ? P_W : 40;

  typedef enum logic [18:0] {
    S_IDLE    = 19'h00001,
    S_SRCH    = 19'h00002,
    S_SCMP    = 19'h00004,
    S_FETCH0  = 19'h00008,
    S_FETCH1  = 19'h00010,
    S_FETCH2  = 19'h00020,
    S_BRANCH  = 19'h00040,
    S_MUL_Q   = 19'h00080,
    S_MUL_AS  = 19'h00100,
    S_MUL_ASD = 19'h00200,
    S_DISC    = 19'h00400,
    S_SQRT    = 19'h00800,
    S_MUL_DS  = 19'h01000,
    S_DIV_OV  = 19'h02000,
    S_POS     = 19'h04000,
    S_THB     = 19'h08000,
    S_MUL_TH  = 19'h10000,
    S_DIV_TH  = 19'h20000,
    S_DONE    = 19'h40000
  } state_t;

  state_t state;

  // configuration
  logic [8:0]  low_rows;
  logic [7:0]  high_rows;
  logic [30:0] lim;
  logic [47:0] total;

  always_ff @(posedge clk) begin
    if (rst) begin
      low_rows  <= 9'd1;
      high_rows <= 8'd0;
      lim       <= 31'd843314856;
      total     <= 48'd1;
    end else if (cfg_we) begin
      case (ticds_pkg::reg_idx_t'(cfg_addr))
        ticds_pkg::REG_LOW_ROWS:  low_rows  <= cfg_data[8:0];
        ticds_pkg::REG_HIGH_ROWS: high_rows <= cfg_data[7:0];
        ticds_pkg::REG_LIMIT:     lim       <= cfg_data[30:0];
        ticds_pkg::REG_TOTAL:     total     <= cfg_data;
        default: ;
      endcase
    end
  end

  // input fields
  ticds_pkg::cmd_t in_cmd;
  logic [8:0]      in_index;
  logic [32:0]     in_value;
  logic [31:0]     in_lookup;
  logic            accept;

  assign in_cmd    = ticds_pkg::cmd_t'(s_tuser);
  assign in_index  = s_tdata[8:0];
  assign in_value  = s_tdata[41:9];
  assign in_lookup = s_tdata[73:42];
  assign s_tready  = (state == S_IDLE);
  assign accept    = s_tvalid && s_tready;

  // tables
  logic [32:0]           cdf_mem [ROWS];
  logic [VALUE_BITS-1:0] sum_mem [ROWS+1];
  logic [CDF_AW-1:0]     cdf_raddr;
  logic [SUM_AW-1:0]     sum_raddr;
  logic [32:0]           cdf_rd;
  logic [VALUE_BITS-1:0] sum_rd;

  always_ff @(posedge clk) begin
    if (accept && (in_cmd == ticds_pkg::CMD_CDF) && ({23'b0, in_index} < 32'(ROWS))) begin
      cdf_mem[CDF_AW'(in_index)] <= in_value;
    end
    cdf_rd <= cdf_mem[cdf_raddr];
  end

  always_ff @(posedge clk) begin
    if (accept && (in_cmd == ticds_pkg::CMD_SUM) && ({23'b0, in_index} < 32'(ROWS + 1))) begin
      sum_mem[SUM_AW'(in_index)] <= VALUE_BITS'(in_value);
    end
    sum_rd <= sum_mem[sum_raddr];
  end

  // working registers
  logic [31:0]           lookup;
  logic [N_W-1:0]        lo;
  logic [N_W-1:0]        hi;
  logic [N_W-1:0]        n_rows;
  logic [32:0]           c0;
  logic [32:0]           c1;
  logic [VALUE_BITS-1:0] s0;
  logic [VALUE_BITS-1:0] s1;
  logic                  neg;
  logic                  first_half;
  logic                  band_low;
  logic [127:0]          qsq;
  logic [127:0]          p2;
  logic [P_W-1:0]        pos;
  logic [30:0]           theta_r;
  logic [8:0]            bin_r;
  logic [31:0]           ov_r;

  // derived values
  logic [CW-1:0]         rows_sum;
  logic [N_W-1:0]        n_c;
  logic [N_W:0]          mid_sum;
  logic [N_W-1:0]        mid;
  logic [N_W-1:0]        lo_m1;
  logic signed [N_W:0]   idx_s;
  logic [31:0]           dy;
  logic [VALUE_BITS-1:0] ad;
  logic [127:0]          disc;
  logic [30:0]           span;
  logic [P_W-1:0]        pos_c;
  logic [CMP_W-1:0]      low_pos;
  logic [CMP_W-1:0]      pos_diff;
  logic                  pos_low_c;
  logic [32:0]           ov_first;
  logic [31:0]           theta_sum;

  always_comb begin
    rows_sum = CW'(low_rows) + CW'(high_rows);
    if (rows_sum > CW'(ROWS)) begin
      n_c = N_W'(ROWS);
    end else if (rows_sum == '0) begin
      n_c = N_W'(1);
    end else begin
      n_c = N_W'(rows_sum);
    end
    mid_sum   = {1'b0, lo} + {1'b0, hi};
    mid       = mid_sum[N_W:1];
    lo_m1     = lo - 1'b1;
    idx_s     = $signed({1'b0, lo}) - $signed((N_W+1)'(1));
    dy        = ({1'b0, lookup} >= c0) ? (lookup - c0[31:0]) : 32'd0;
    ad        = neg ? (s0 - s1) : (s1 - s0);
    if (neg) begin
      disc = (qsq >= p2) ? (qsq - p2) : 128'd0;
    end else begin
      disc = qsq + p2;
    end
    span      = (lim < ticds_pkg::HALF_PI_Q30) ? (ticds_pkg::HALF_PI_Q30 - lim) : 31'd0;
    pos_c     = (P_W'(lo) << 31) + P_W'(ov_r) - P_W'(ticds_pkg::HALF_Q31);
    low_pos   = CMP_W'(low_rows) << 31;
    pos_low_c = CMP_W'(pos) < low_pos;
    pos_diff  = CMP_W'(pos) - low_pos;
  end

  // table read addresses
  always_comb begin
    cdf_raddr = CDF_AW'(mid);
    sum_raddr = SUM_AW'(lo_m1);
    case (state)
      S_FETCH0: begin
        cdf_raddr = (lo == '0) ? '0 : CDF_AW'(lo_m1);
        sum_raddr = SUM_AW'(lo_m1);
      end
      S_FETCH1: begin
        cdf_raddr = CDF_AW'(lo);
        sum_raddr = SUM_AW'(lo);
      end
      default: ;
    endcase
  end

  // serial units
  logic                           mul_start;
  logic [ticds_pkg::MUL_A_W-1:0]  mul_a;
  logic [ticds_pkg::MUL_B_W-1:0]  mul_b;
  logic                           mul_done;
  logic [ticds_pkg::MUL_P_W-1:0]  mul_p;
  logic                           div_start;
  logic [ticds_pkg::DIV_N_W-1:0]  div_num;
  logic [ticds_pkg::DIV_D_W-1:0]  div_den;
  logic [ticds_pkg::DIV_Q_W-1:0]  div_cap;
  logic                           div_done;
  logic [ticds_pkg::DIV_Q_W-1:0]  div_q;
  logic                           sq_start;
  logic                           sq_done;
  logic [ticds_pkg::SQRT_R_W-1:0] sq_root;

  ticds_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .p     (mul_p)
  );

  ticds_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .cap   (div_cap),
    .done  (div_done),
    .q     (div_q)
  );

  ticds_sqrt u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sq_start),
    .num   (disc),
    .done  (sq_done),
    .root  (sq_root)
  );

  assign sq_start = (state == S_DISC);

  always_comb begin
    mul_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    div_cap   = ticds_pkg::ONE_Q31;
    case (state)
      S_BRANCH: begin
        if (lo == '0) begin
          div_start = 1'b1;
          div_num   = ticds_pkg::DIV_N_W'({lookup, 30'b0});
          div_den   = ticds_pkg::DIV_D_W'(c0);
        end else if (lo == n_rows) begin
          div_start = (c0 <= {1'b0, lookup});
          div_num   = ticds_pkg::DIV_N_W'({lookup - c0[31:0], 30'b0});
          div_den   = ticds_pkg::DIV_D_W'(ticds_pkg::ONE_Q32 - c0);
        end else if (s0 == s1) begin
          div_start = (c1 > c0);
          div_num   = ticds_pkg::DIV_N_W'({dy, 31'b0});
          div_den   = ticds_pkg::DIV_D_W'(c1 - c0);
        end else begin
          mul_start = 1'b1;
          mul_a     = ticds_pkg::MUL_A_W'(s0);
          mul_b     = ticds_pkg::MUL_B_W'(s0);
        end
      end
      S_MUL_Q: begin
        mul_start = mul_done;
        mul_a     = ticds_pkg::MUL_A_W'(total);
        mul_b     = ticds_pkg::MUL_B_W'(ad);
      end
      S_MUL_AS: begin
        mul_start = mul_done;
        mul_a     = mul_p[ticds_pkg::MUL_A_W-1:0];
        mul_b     = ticds_pkg::MUL_B_W'(dy);
      end
      S_SQRT: begin
        mul_start = sq_done;
        mul_a     = ticds_pkg::MUL_A_W'(total);
        mul_b     = ticds_pkg::MUL_B_W'(dy);
      end
      S_MUL_DS: begin
        div_start = mul_done;
        div_num   = ticds_pkg::DIV_N_W'({mul_p[ticds_pkg::MUL_A_W-1:0], 16'b0});
        div_den   = ticds_pkg::DIV_D_W'({s0, 16'b0}) + ticds_pkg::DIV_D_W'(sq_root);
      end
      S_THB: begin
        mul_start = pos_low_c || (high_rows != '0);
        mul_a     = pos_low_c ? ticds_pkg::MUL_A_W'(pos) : ticds_pkg::MUL_A_W'(pos_diff);
        mul_b     = pos_low_c ? ticds_pkg::MUL_B_W'(lim) : ticds_pkg::MUL_B_W'(span);
      end
      S_MUL_TH: begin
        div_start = mul_done;
        div_num   = mul_p[ticds_pkg::DIV_N_W-1:0];
        div_den   = band_low ? ticds_pkg::DIV_D_W'({low_rows, 31'b0})
                             : ticds_pkg::DIV_D_W'({high_rows, 31'b0});
        div_cap   = {1'b0, ticds_pkg::THETA_MAX};
      end
      default: ;
    endcase
  end

  assign ov_first  = {1'b0, ticds_pkg::HALF_Q31} + {1'b0, div_q};
  assign theta_sum = {1'b0, lim} + div_q;

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            state <= (in_cmd == ticds_pkg::CMD_SAMPLE) ? S_SRCH : S_DONE;
          end
        end
        S_SRCH:    state <= (lo < hi) ? S_SCMP : S_FETCH0;
        S_SCMP:    state <= S_SRCH;
        S_FETCH0:  state <= S_FETCH1;
        S_FETCH1:  state <= S_FETCH2;
        S_FETCH2:  state <= S_BRANCH;
        S_BRANCH: begin
          if (mul_start) begin
            state <= S_MUL_Q;
          end else if (div_start) begin
            state <= S_DIV_OV;
          end else begin
            state <= S_POS;
          end
        end
        S_MUL_Q:   if (mul_done) state <= S_MUL_AS;
        S_MUL_AS:  if (mul_done) state <= S_MUL_ASD;
        S_MUL_ASD: if (mul_done) state <= S_DISC;
        S_DISC:    state <= S_SQRT;
        S_SQRT:    if (sq_done) state <= S_MUL_DS;
        S_MUL_DS:  if (mul_done) state <= S_DIV_OV;
        S_DIV_OV:  if (div_done) state <= S_POS;
        S_POS:     state <= S_THB;
        S_THB:     state <= mul_start ? S_MUL_TH : S_DONE;
        S_MUL_TH:  if (mul_done) state <= S_DIV_TH;
        S_DIV_TH:  if (div_done) state <= S_DONE;
        S_DONE:    if (!m_tvalid || m_tready) state <= S_IDLE;
        default:   state <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept) begin
          lookup  <= in_lookup;
          lo      <= '0;
          hi      <= n_c;
          n_rows  <= n_c;
          theta_r <= '0;
          bin_r   <= '0;
          ov_r    <= '0;
        end
      end
      S_SCMP: begin
        if (cdf_rd <= {1'b0, lookup}) begin
          lo <= mid + 1'b1;
        end else begin
          hi <= mid;
        end
      end
      S_FETCH1: begin
        c0 <= cdf_rd;
        s0 <= sum_rd;
      end
      S_FETCH2: begin
        c1  <= cdf_rd;
        s1  <= sum_rd;
        neg <= (sum_rd < s0);
      end
      S_BRANCH: begin
        bin_r      <= 9'(idx_s);
        first_half <= (lo == '0);
        ov_r       <= '0;
      end
      S_MUL_Q: begin
        if (mul_done) begin
          qsq <= {mul_p[95:0], 32'b0};
        end
      end
      S_MUL_ASD: begin
        if (mul_done) begin
          p2 <= {mul_p[126:0], 1'b0};
        end
      end
      S_DIV_OV: begin
        if (div_done) begin
          if (first_half) begin
            ov_r <= (ov_first > {1'b0, ticds_pkg::ONE_Q31}) ? ticds_pkg::ONE_Q31
                                                            : ov_first[31:0];
          end else begin
            ov_r <= div_q;
          end
        end
      end
      S_POS: pos <= pos_c;
      S_THB: begin
        band_low <= pos_low_c;
        if (!pos_low_c && (high_rows == '0)) begin
          theta_r <= lim;
        end
      end
      S_DIV_TH: begin
        if (div_done) begin
          if (band_low) begin
            theta_r <= div_q[30:0];
          end else begin
            theta_r <= theta_sum[31] ? ticds_pkg::THETA_MAX : theta_sum[30:0];
          end
        end
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if ((state == S_DONE) && (!m_tvalid || m_tready)) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_DONE) && (!m_tvalid || m_tready)) begin
      m_tdata <= {ov_r, bin_r, theta_r};
    end
  end

endmodule
`default_nettype wire

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// testbench: self-checking bench for theta_inverse_cdf_sampler_core
// Drives load, sample and no-op beats, with random gaps on both stream sides
// in most phases, predicts output beats with a bit-accurate sampler model kept
// here or a fixed expected beat, and compares each received beat field by field in order.
// ----------------------------------------------------------------------------
module testbench;

  typedef struct packed {
    logic [30:0] theta;
    logic [8:0]  bin;
    logic [31:0] ovs;
  } angle_beat_t;

  typedef struct {
    bit          is_cfg;
    logic [1:0]  code;
    logic [8:0]  row;
    logic [47:0] value;
    logic [31:0] lookup;
    bit          typed;
    angle_beat_t want;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [79:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [71:0] m_tdata;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_addr = '0;
  logic [47:0] cfg_data = '0;

  logic [32:0] cdf_mem [256];
  logic [31:0] hits_mem [257];
  logic [8:0]  low_rows;
  logic [7:0]  high_rows;
  logic [30:0] limit_q30;
  logic [47:0] hits_total;

  angle_beat_t pending_angles[$];
  stim_row_t   plan[$];
  int          mismatches = 0;
  int          rx_wait = 0;
  int          rx_next = 0;
  int          rx_beats = 0;
  int          rx_seen = 0;
  bit          gaps_on = 1'b1;

  theta_inverse_cdf_sampler_core dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  initial begin
    #40000000;
    $display("simulation failed");
    $finish;
  end

  function automatic logic [63:0] div_sat(logic [127:0] n, logic [127:0] d, logic [63:0] cap);
    logic [127:0] q;
    if (d == 0) return 64'd0;
    q = n / d;
    return (q > 128'(cap)) ? cap : q[63:0];
  endfunction

  function automatic logic [63:0] root_floor(logic [127:0] x);
    logic [127:0] res, bitv, t;
    res = 0;
    bitv = 128'd1 << 126;
    while (bitv != 0) begin
      t = res + bitv;
      if (x >= t) begin
        x = x - t;
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res[63:0];
  endfunction

  function automatic logic [30:0] angle_of(int idx, logic [63:0] ovs);
    logic [63:0] p, k, span, th;
    p = (64'(idx + 1) << 31) + ovs - (64'd1 << 30);
    k = p >> 31;
    if (k < 64'(low_rows)) begin
      th = div_sat(128'(limit_q30) * 128'(p), 128'(low_rows) << 31, 64'h7fff_ffff);
      return th[30:0];
    end
    if (high_rows == 0) return limit_q30;
    span = (limit_q30 < ticds_pkg::HALF_PI_Q30) ? 64'(ticds_pkg::HALF_PI_Q30 - limit_q30)
                                                : 64'd0;
    th = 64'(limit_q30) + div_sat(128'(span) * 128'(p - (64'(low_rows) << 31)),
                                  128'(high_rows) << 31, 64'h7fff_ffff);
    return (th > 64'h7fff_ffff) ? ticds_pkg::THETA_MAX : th[30:0];
  endfunction

  function automatic angle_beat_t sample_angle(logic [1:0] code, logic [8:0] ei,
                                               logic [32:0] ev, logic [31:0] lk);
    angle_beat_t r;
    logic [63:0] n, lo, hi, mid, ovs, c, c0, c1, s0, s1, dy, ad, rt, d;
    logic [127:0] q, p2, disc;
    int idx;
    r = '0;
    if (code == ticds_pkg::CMD_CDF) begin
      if (ei < 256) cdf_mem[ei] = ev;
      return r;
    end
    if (code == ticds_pkg::CMD_SUM) begin
      if (ei < 257) hits_mem[ei] = ev[31:0];
      return r;
    end
    if (code != ticds_pkg::CMD_SAMPLE) return r;
    n = 64'(low_rows) + 64'(high_rows);
    if (n > 256) n = 256;
    if (n < 1) n = 1;
    lo = 0;
    hi = n;
    while (lo < hi) begin
      mid = (lo + hi) >> 1;
      if (64'(cdf_mem[mid]) <= 64'(lk)) lo = mid + 1;
      else hi = mid;
    end
    idx = int'(lo) - 1;
    if (idx < 0) begin
      c = 64'(cdf_mem[0]);
      ovs = (c != 0) ? (64'd1 << 30) + (64'(lk) << 30) / c : 64'd0;
    end else if (64'(idx) == n - 1) begin
      c = 64'(cdf_mem[idx]);
      d = (64'd1 << 32) - c;
      ovs = (c <= 64'(lk) && d != 0) ? ((64'(lk) - c) << 30) / d : 64'd0;
    end else begin
      c0 = 64'(cdf_mem[idx]);
      c1 = 64'(cdf_mem[idx + 1]);
      s0 = 64'(hits_mem[idx]);
      s1 = 64'(hits_mem[idx + 1]);
      dy = (64'(lk) >= c0) ? 64'(lk) - c0 : 64'd0;
      if (s0 == s1) begin
        ovs = (c1 > c0) ? div_sat(128'(dy) << 31, 128'(c1 - c0), 64'(ticds_pkg::ONE_Q31))
                        : 64'd0;
      end else begin
        q = (128'(s0) * 128'(s0)) << 32;
        ad = (s1 < s0) ? s0 - s1 : s1 - s0;
        p2 = (128'(ad) * 128'(hits_total) * 128'(dy)) << 1;
        if (s1 > s0) disc = q + p2;
        else disc = (q >= p2) ? q - p2 : 128'd0;
        rt = root_floor(disc);
        ovs = div_sat((128'(dy) * 128'(hits_total)) << 16, (128'(s0) << 16) + 128'(rt),
                      64'(ticds_pkg::ONE_Q31));
      end
    end
    if (ovs > 64'(ticds_pkg::ONE_Q31)) ovs = 64'(ticds_pkg::ONE_Q31);
    r.theta = angle_of(idx, ovs);
    r.bin = idx[8:0];
    r.ovs = ovs[31:0];
    return r;
  endfunction

  task automatic write_reg(ticds_pkg::reg_idx_t a, logic [47:0] v);
    wait (pending_angles.size() == 0);
    repeat (8) @(negedge clk);
    cfg_we = 1'b1;
    cfg_addr = a;
    cfg_data = v;
    @(negedge clk);
    cfg_we = 1'b0;
    case (a)
      ticds_pkg::REG_LOW_ROWS:  low_rows = v[8:0];
      ticds_pkg::REG_HIGH_ROWS: high_rows = v[7:0];
      ticds_pkg::REG_LIMIT:     limit_q30 = v[30:0];
      default:                  hits_total = v;
    endcase
  endtask

  task automatic send_beat(logic [1:0] code, logic [8:0] row, logic [32:0] value,
                           logic [31:0] lk, bit typed, angle_beat_t want);
    int gap;
    angle_beat_t got;
    gap = gaps_on ? $urandom_range(0, 14) : 0;
    if (gap > 0) begin
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tuser = code;
    s_tdata = {6'd0, lk, value, row};
    s_tvalid = 1'b1;
    do @(posedge clk); while (!s_tready);
    got = sample_angle(code, row, value, lk);
    pending_angles.push_back(typed ? want : got);
    @(negedge clk);
    s_tvalid = 1'b0;
  endtask

  task automatic add_row(bit is_cfg, logic [1:0] code, logic [8:0] row, logic [47:0] value,
                         logic [31:0] lk, bit typed, angle_beat_t want);
    stim_row_t e;
    e.is_cfg = is_cfg;
    e.code = code;
    e.row = row;
    e.value = value;
    e.lookup = lk;
    e.typed = typed;
    e.want = want;
    plan.push_back(e);
  endtask

  always @(negedge clk) begin
    if (!rst) begin
      if (rx_seen != rx_beats) begin
        rx_seen = rx_beats;
        rx_wait = rx_next;
      end
      if (rx_wait > 0) begin
        m_tready <= 1'b0;
        rx_wait = rx_wait - 1;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    angle_beat_t act, want;
    if (!rst && m_tvalid && m_tready) begin
      act.theta = m_tdata[30:0];
      act.bin = m_tdata[39:31];
      act.ovs = m_tdata[71:40];
      if (pending_angles.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected beat %h", m_tdata);
      end else begin
        want = pending_angles.pop_front();
        if (act !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch theta %0d/%0d bin %0d/%0d overshoot %0d/%0d (exp/act)",
                     want.theta, act.theta, $signed(want.bin), $signed(act.bin),
                     want.ovs, act.ovs);
        end
      end
      rx_next = gaps_on ? $urandom_range(0, 14) : 0;
      rx_beats++;
    end
  end

  initial begin
    angle_beat_t z, w;
    logic [32:0] v;
    logic [31:0] lk;
    logic [8:0]  row;
    logic [1:0]  code;
    int pick;
    low_rows = 9'd1;
    high_rows = 8'd0;
    limit_q30 = 31'd843314856;
    hits_total = 48'd1;
    z = '0;
    w.theta = 31'd0;
    w.bin = 9'h1ff;
    w.ovs = ticds_pkg::HALF_Q31;

    add_row(0, ticds_pkg::CMD_CDF, 9'd0, 48'h8000_0000, 0, 1, z);
    add_row(0, ticds_pkg::CMD_SUM, 9'd0, 48'd5, 0, 1, z);
    add_row(0, ticds_pkg::CMD_CDF, 9'd256, 48'h1_ffff_ffff, 32'hffff_ffff, 1, z);
    add_row(0, ticds_pkg::CMD_SUM, 9'd511, 48'h1_ffff_ffff, 32'hffff_ffff, 1, z);
    add_row(0, ticds_pkg::CMD_NOP, 9'd511, 48'h1_ffff_ffff, 32'hffff_ffff, 1, z);
    add_row(0, ticds_pkg::CMD_SAMPLE, 9'd0, 0, 32'd0, 1, w);
    add_row(0, ticds_pkg::CMD_SAMPLE, 9'd0, 0, 32'hffff_ffff, 0, z);
    add_row(0, ticds_pkg::CMD_CDF, 9'd0, 48'd0, 0, 1, z);
    add_row(0, ticds_pkg::CMD_SAMPLE, 9'd0, 0, 32'd0, 0, z);
    add_row(0, ticds_pkg::CMD_CDF, 9'd0, 48'h1_0000_0000, 0, 1, z);
    add_row(0, ticds_pkg::CMD_SAMPLE, 9'd0, 0, 32'hffff_ffff, 0, z);
    add_row(1, ticds_pkg::REG_LOW_ROWS, 0, 48'd4, 0, 0, z);
    add_row(1, ticds_pkg::REG_TOTAL, 0, 48'hffff_ffff_ffff, 0, 0, z);
    add_row(0, ticds_pkg::CMD_CDF, 9'd0, 48'h1000_0000, 0, 1, z);
    add_row(0, ticds_pkg::CMD_CDF, 9'd1, 48'h4000_0000, 0, 1, z);
    add_row(0, ticds_pkg::CMD_CDF, 9'd2, 48'h8000_0000, 0, 1, z);
    add_row(0, ticds_pkg::CMD_CDF, 9'd3, 48'hc000_0000, 0, 1, z);
    add_row(0, ticds_pkg::CMD_SUM, 9'd1, 48'd5, 0, 1, z);
    add_row(0, ticds_pkg::CMD_SUM, 9'd2, 48'd50, 0, 1, z);
    add_row(0, ticds_pkg::CMD_SUM, 9'd3, 48'd10, 0, 1, z);
    add_row(0, ticds_pkg::CMD_SAMPLE, 0, 0, 32'h2000_0000, 0, z);
    add_row(0, ticds_pkg::CMD_SAMPLE, 0, 0, 32'h5000_0000, 0, z);
    add_row(0, ticds_pkg::CMD_SAMPLE, 0, 0, 32'h9000_0000, 0, z);
    add_row(0, ticds_pkg::CMD_SAMPLE, 0, 0, 32'hf000_0000, 0, z);
    add_row(0, ticds_pkg::CMD_SAMPLE, 0, 0, 32'h0, 0, z);

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (plan[i]) begin
      if (plan[i].is_cfg) write_reg(ticds_pkg::reg_idx_t'(plan[i].code), plan[i].value);
      else send_beat(plan[i].code, plan[i].row, plan[i].value[32:0], plan[i].lookup,
                     plan[i].typed, plan[i].want);
    end

    for (int i = 0; i < 256; i++)
      send_beat(ticds_pkg::CMD_CDF, 9'(i), 33'((i << 24) | $urandom_range(0, 24'hffffff)),
                $urandom, 0, z);
    for (int i = 0; i < 257; i++)
      send_beat(ticds_pkg::CMD_SUM, 9'(i), 33'($urandom_range(0, 5000)), $urandom, 0, z);

    for (int ph = 0; ph < 8; ph++) begin
      gaps_on = (ph % 3 != 1);
      case (ph)
        0: pick = 256;
        1: pick = 1;
        2: pick = 0;
        3: pick = 511;
        default: pick = $urandom_range(1, 256);
      endcase
      write_reg(ticds_pkg::REG_LOW_ROWS, 48'(pick));
      write_reg(ticds_pkg::REG_HIGH_ROWS, (ph == 1 || ph == 3) ? 48'd255 :
                (ph == 0) ? 48'd0 : 48'($urandom_range(0, 255)));
      write_reg(ticds_pkg::REG_LIMIT, (ph == 1) ? 48'd0 : (ph == 3) ? 48'h7fff_ffff :
                (ph == 2) ? 48'(ticds_pkg::HALF_PI_Q30) :
                48'($urandom_range(0, 1686629713)));
      write_reg(ticds_pkg::REG_TOTAL, (ph == 0) ? 48'd1 : (ph == 1) ? 48'hffff_ffff_ffff :
                {16'($urandom_range(0, 16'hffff)), $urandom} | 48'd1);
      for (int it = 0; it < 130; it++) begin
        pick = $urandom_range(0, 99);
        row = ($urandom_range(0, 9) == 0) ? 9'($urandom_range(0, 511))
                                          : 9'($urandom_range(0, 256));
        v = {1'($urandom_range(0, 1)), $urandom};
        lk = $urandom;
        if (pick < 55) begin
          code = ticds_pkg::CMD_SAMPLE;
          case ($urandom_range(0, 5))
            0: lk = 32'd0;
            1: lk = 32'hffff_ffff;
            2, 3: lk = cdf_mem[$urandom_range(0, 255)][31:0] + $urandom_range(0, 3);
            default: ;
          endcase
        end else if (pick < 75) begin
          code = ticds_pkg::CMD_CDF;
          case ($urandom_range(0, 5))
            0: v = 33'h1_0000_0000;
            1: v = 33'd0;
            2: ;
            default: v = 33'((row << 24) | $urandom_range(0, 24'hffffff));
          endcase
        end else if (pick < 95) begin
          code = ticds_pkg::CMD_SUM;
          case ($urandom_range(0, 4))
            0: if (row > 0 && row < 257) v = 33'(hits_mem[row - 1]);
            1: v = 33'($urandom_range(0, 1000));
            2: v = 33'd0;
            default: ;
          endcase
        end else begin
          code = ticds_pkg::CMD_NOP;
        end
        send_beat(code, row, v, lk, 0, z);
      end
    end

    s_tvalid = 1'b0;
    wait (pending_angles.size() == 0);
    repeat (20) @(posedge clk);
    if (mismatches == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end
endmodule
